[sv/bpr_pkg.sv]
// bpr_pkg: shared constants for the bezier point rasterizer
// register indexes, write modes, default widths and queue sizing
// no dependencies
package bpr_pkg;

    localparam int DEFAULT_COORD_BITS  = 10;
    localparam int DEFAULT_T_FRAC_BITS = 16;

    localparam int NUM_CTRL_POINTS = 4;
    localparam int CFG_INDEX_BITS  = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CTRL_POINT_0 = 3'd0,
        REG_CTRL_POINT_1 = 3'd1,
        REG_CTRL_POINT_2 = 3'd2,
        REG_CTRL_POINT_3 = 3'd3,
        REG_AA_ENABLE    = 3'd4
    } cfg_reg_t;

    localparam logic       MODE_GREEN    = 1'b0;
    localparam logic       MODE_WEIGHTED = 1'b1;
    localparam logic [7:0] WEIGHT_FULL   = 8'd255;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;

    // emission step of one point
    typedef enum logic [1:0] {
        STEP_OWN  = 2'd0,
        STEP_X    = 2'd1,
        STEP_Y    = 2'd2,
        STEP_DIAG = 2'd3
    } step_t;

endpackage

[sv/bpr_if.sv]
// bpr_t_if, bpr_pix_if: valid/ready channels of the rasterizer
// depends on nothing
interface bpr_t_if #(parameter int T_W = 17);
    logic           valid;
    logic           ready;
    logic [T_W-1:0] t_value;
    modport source (output valid, output t_value, input ready);
    modport sink (input valid, input t_value, output ready);
endinterface

interface bpr_pix_if #(parameter int P_W = 12);
    logic                  valid;
    logic                  ready;
    logic signed [P_W-1:0] pixel_x;
    logic signed [P_W-1:0] pixel_y;
    logic                  write_mode;
    logic [7:0]            weight;
    logic                  last;
    modport source (output valid, output pixel_x, output pixel_y, output write_mode,
                    output weight, output last, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input write_mode,
                  input weight, input last, output ready);
endinterface

[sv/bpr_front.sv]
// bpr_front: t saturation and three-level de casteljau pipeline
// depends on bpr_pkg
module bpr_front
    import bpr_pkg::*;
#(
    parameter int COORD_BITS  = DEFAULT_COORD_BITS,
    parameter int T_FRAC_BITS = DEFAULT_T_FRAC_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [T_FRAC_BITS:0]            t_value,
    input  logic [2*COORD_BITS-1:0]         ctrl_point [NUM_CTRL_POINTS],
    output logic                            push_valid,
    input  logic                            push_ready,
    output logic [2*COORD_BITS+1:0]         push_data
);

    localparam int F = T_FRAC_BITS;
    localparam int W = COORD_BITS + T_FRAC_BITS;
    localparam logic [F:0] ONE_T = {1'b1, {F{1'b0}}};

    function automatic logic [W-1:0] lerp(input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [F:0] t);
        logic [W+F:0]   pa;
        logic [W+F:0]   pb;
        logic [W+F+1:0] s;
        pa = {{(F+1){1'b0}}, a} * {{W{1'b0}}, ONE_T - t};
        pb = {{(F+1){1'b0}}, b} * {{W{1'b0}}, t};
        s  = {1'b0, pa} + {1'b0, pb};
        return s[W+F-1:F];
    endfunction

    logic [F:0]   t_sat;
    logic [W-1:0] xs [NUM_CTRL_POINTS];
    logic [W-1:0] ys [NUM_CTRL_POINTS];
    logic         advance;

    logic         v1_reg, v2_reg, v3_reg;
    logic [F:0]   t1_reg, t2_reg;
    logic [W-1:0] xa_reg, xb_reg, xc_reg, ya_reg, yb_reg, yc_reg;
    logic [W-1:0] xd_reg, xe_reg, yd_reg, ye_reg;
    logic [W-1:0] px_reg, py_reg;

    always_comb
    begin
        t_sat = (t_value > ONE_T) ? ONE_T : t_value;
        for (int i = 0; i < NUM_CTRL_POINTS; i++)
        begin
            xs[i] = {ctrl_point[i][COORD_BITS-1:0], {F{1'b0}}};
            ys[i] = {ctrl_point[i][2*COORD_BITS-1:COORD_BITS], {F{1'b0}}};
        end
    end

    assign advance  = !v3_reg || push_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t1_reg <= t_sat;
            xa_reg <= lerp(xs[0], xs[1], t_sat);
            xb_reg <= lerp(xs[1], xs[2], t_sat);
            xc_reg <= lerp(xs[2], xs[3], t_sat);
            ya_reg <= lerp(ys[0], ys[1], t_sat);
            yb_reg <= lerp(ys[1], ys[2], t_sat);
            yc_reg <= lerp(ys[2], ys[3], t_sat);
            t2_reg <= t1_reg;
            xd_reg <= lerp(xa_reg, xb_reg, t1_reg);
            xe_reg <= lerp(xb_reg, xc_reg, t1_reg);
            yd_reg <= lerp(ya_reg, yb_reg, t1_reg);
            ye_reg <= lerp(yb_reg, yc_reg, t1_reg);
            px_reg <= lerp(xd_reg, xe_reg, t2_reg);
            py_reg <= lerp(yd_reg, ye_reg, t2_reg);
        end
    end

    // entry: neg y side, neg x side, row, column
    assign push_valid = v3_reg;
    assign push_data  = {~py_reg[F-1], ~px_reg[F-1], py_reg[W-1:F], px_reg[W-1:F]};

endmodule

[sv/bpr_queue.sv]
// bpr_queue: small fifo between the curve pipeline and the write sequencer
// depends on bpr_pkg
module bpr_queue
    import bpr_pkg::*;
#(
    parameter int DATA_W = 2*DEFAULT_COORD_BITS + 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0]       mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;
    logic                      push, pop;

    assign push_ready = count_reg != QUEUE_PTR_BITS'(0) + (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

[sv/bpr_back.sv]
// bpr_back: pixel write sequencer with output register
// depends on bpr_pkg
module bpr_back
    import bpr_pkg::*;
#(
    parameter int COORD_BITS = DEFAULT_COORD_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    aa_enable,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  logic [2*COORD_BITS+1:0] pop_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [COORD_BITS+1:0]   out_x,
    output logic [COORD_BITS+1:0]   out_y,
    output logic                    out_mode,
    output logic [7:0]              out_weight,
    output logic                    out_last
);

    localparam int P_W = COORD_BITS + 2;

    logic                  load;
    logic                  busy_reg;
    step_t                 step_reg;
    logic [2*COORD_BITS+1:0] pt_reg;
    logic [2*COORD_BITS+1:0] pt;
    step_t                 step;
    logic [P_W-1:0]        base_x, base_y, nb_x, nb_y;
    logic                  valid_reg, mode_reg, last_reg;
    logic [P_W-1:0]        x_reg, y_reg;
    logic [7:0]            weight_reg;

    assign load      = !valid_reg || out_ready;
    assign pop_ready = load && !busy_reg;

    always_comb
    begin
        pt     = busy_reg ? pt_reg : pop_data;
        step   = busy_reg ? step_reg : STEP_OWN;
        base_x = {2'b00, pt[COORD_BITS-1:0]};
        base_y = {2'b00, pt[2*COORD_BITS-1:COORD_BITS]};
        nb_x   = base_x + (pt[2*COORD_BITS] ? {P_W{1'b1}} : P_W'(1));
        nb_y   = base_y + (pt[2*COORD_BITS+1] ? {P_W{1'b1}} : P_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= STEP_OWN;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            if (busy_reg || pop_valid)
            begin
                valid_reg <= 1'b1;
                unique case (step)
                    STEP_OWN:
                    begin
                        busy_reg <= aa_enable;
                        step_reg <= STEP_X;
                    end
                    STEP_X:    step_reg <= STEP_Y;
                    STEP_Y:    step_reg <= STEP_DIAG;
                    STEP_DIAG:
                    begin
                        busy_reg <= 1'b0;
                        step_reg <= STEP_OWN;
                    end
                    default:   step_reg <= STEP_OWN;
                endcase
            end
            else
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (!busy_reg)
                pt_reg <= pop_data;
            weight_reg <= WEIGHT_FULL;
            unique case (step)
                STEP_OWN:
                begin
                    x_reg    <= base_x;
                    y_reg    <= base_y;
                    mode_reg <= MODE_GREEN;
                    last_reg <= !aa_enable;
                end
                STEP_X:
                begin
                    x_reg    <= nb_x;
                    y_reg    <= base_y;
                    mode_reg <= MODE_WEIGHTED;
                    last_reg <= 1'b0;
                end
                STEP_Y:
                begin
                    x_reg    <= base_x;
                    y_reg    <= nb_y;
                    mode_reg <= MODE_WEIGHTED;
                    last_reg <= 1'b0;
                end
                STEP_DIAG:
                begin
                    x_reg    <= nb_x;
                    y_reg    <= nb_y;
                    mode_reg <= MODE_WEIGHTED;
                    last_reg <= 1'b1;
                end
                default:
                begin
                    x_reg    <= base_x;
                    y_reg    <= base_y;
                    mode_reg <= MODE_GREEN;
                    last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid  = valid_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
    assign out_mode   = mode_reg;
    assign out_weight = weight_reg;
    assign out_last   = last_reg;

endmodule

[sv/bezier_point_rasterizer_aa_unit.sv]
// bezier_point_rasterizer_aa_unit: cubic bezier point to pixel writes
// depends on bpr_pkg, bpr_if, bpr_front, bpr_queue, bpr_back
//
// usage
// t_in takes one curve parameter t (Q1.F, values above 1.0 clamp) per transfer.
// pix_out gives one pixel write per transfer: the own pixel (green set) and,
// with aa_enable set, three neighbour writes of weight 255; last marks the
// final write of each t. off-window neighbours come out as -1 or 2^COORD_BITS.
// control points and aa_enable are written through cfg_we/cfg_index/cfg_data;
// the user must do so while the unit is idle, the unit does not enforce it.
// a t transfer reaches its first write, when nothing stalls, through the
// three lerp stages, one queue slot and the output register.
// throughput, while pix_out is ready: one t per cycle with anti-aliasing off;
// with it on, the write sequencer gives one write per cycle, four writes per t.
// a stalled receiver holds the output register; the 4-entry queue fills, then
// the lerp pipeline holds and t_in.ready drops.
// reset zeroes control and handshake state; the data registers are not reset.
module bezier_point_rasterizer_aa_unit
    import bpr_pkg::*;
#(
    parameter int COORD_BITS  = DEFAULT_COORD_BITS,
    parameter int T_FRAC_BITS = DEFAULT_T_FRAC_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    bpr_t_if.sink                     t_in,
    bpr_pix_if.source                 pix_out,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [2*COORD_BITS-1:0]   cfg_data
);

    localparam int Q_W = 2*COORD_BITS + 2;

    logic [2*COORD_BITS-1:0] ctrl_point_reg [NUM_CTRL_POINTS];
    logic                    aa_enable_reg;
    logic                    push_valid, push_ready, pop_valid, pop_ready;
    logic [Q_W-1:0]          push_data, pop_data;
    logic [COORD_BITS+1:0]   out_x, out_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CTRL_POINTS; i++)
                ctrl_point_reg[i] <= '0;
            aa_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CTRL_POINT_0: ctrl_point_reg[0] <= cfg_data;
                REG_CTRL_POINT_1: ctrl_point_reg[1] <= cfg_data;
                REG_CTRL_POINT_2: ctrl_point_reg[2] <= cfg_data;
                REG_CTRL_POINT_3: ctrl_point_reg[3] <= cfg_data;
                REG_AA_ENABLE:    aa_enable_reg     <= cfg_data[0];
                default:          aa_enable_reg     <= aa_enable_reg;
            endcase
        end
    end

    bpr_front #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (t_in.valid),
        .in_ready   (t_in.ready),
        .t_value    (t_in.t_value),
        .ctrl_point (ctrl_point_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bpr_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bpr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .aa_enable  (aa_enable_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .out_valid  (pix_out.valid),
        .out_ready  (pix_out.ready),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_mode   (pix_out.write_mode),
        .out_weight (pix_out.weight),
        .out_last   (pix_out.last)
    );

    assign pix_out.pixel_x = $signed(out_x);
    assign pix_out.pixel_y = $signed(out_y);

endmodule

[test/tb_top.sv]
// tb_top: self-checking bench for bezier_point_rasterizer_aa_unit
// drives t values and register writes, expects every pixel write and checks each transfer
// depends on bpr_pkg, bpr_if and the unit itself
`timescale 1ns / 100ps

module tb_top;
    import bpr_pkg::*;

    localparam longint unsigned ONE_T  = 64'd1 << DEFAULT_T_FRAC_BITS;
    localparam longint unsigned HALF_T = 64'd1 << (DEFAULT_T_FRAC_BITS - 1);
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic               mode;
        logic [7:0]         weight;
        logic               last;
    } pix_write_t;

    typedef enum bit {ROW_CFG, ROW_T} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cfg_reg_t    idx;
        logic [19:0] data;
        logic [16:0] t;
        bit          typed;
        int          ex;
        int          ey;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [19:0] cfg_data;

    bpr_t_if #(.T_W(17)) t_if ();
    bpr_pix_if #(.P_W(12)) pix_if ();

    bezier_point_rasterizer_aa_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .t_in      (t_if.sink),
        .pix_out   (pix_if.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [19:0] ctrl_shadow [4];
    bit aa_shadow;
    pix_write_t pending_writes [$];
    int errors;
    int idle_cycles;
    bit hold_req;
    bit rx_fast;
    bit tx_fast;

    stim_row_t directed [] = '{
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'd0, 1'b1, 0, 0},
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'd65536, 1'b1, 0, 0},
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'h1FFFF, 1'b1, 0, 0},
        '{ROW_CFG, REG_CTRL_POINT_0, 20'hFFFFF, 17'd0, 1'b0, 0, 0},
        '{ROW_CFG, REG_CTRL_POINT_1, 20'hFFFFF, 17'd0, 1'b0, 0, 0},
        '{ROW_CFG, REG_CTRL_POINT_2, 20'hFFFFF, 17'd0, 1'b0, 0, 0},
        '{ROW_CFG, REG_CTRL_POINT_3, 20'hFFFFF, 17'd0, 1'b0, 0, 0},
        '{ROW_CFG, REG_AA_ENABLE, 20'h1, 17'd0, 1'b0, 0, 0},
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'd0, 1'b1, 1023, 1023},
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'd65536, 1'b1, 1023, 1023},
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'd98304, 1'b1, 1023, 1023},
        '{ROW_CFG, REG_CTRL_POINT_0, 20'h00000, 17'd0, 1'b0, 0, 0},
        '{ROW_CFG, REG_CTRL_POINT_1, 20'h003FF, 17'd0, 1'b0, 0, 0},
        '{ROW_CFG, REG_CTRL_POINT_2, 20'hFFC00, 17'd0, 1'b0, 0, 0},
        '{ROW_CFG, REG_CTRL_POINT_3, 20'h7FDFF, 17'd0, 1'b0, 0, 0},
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'd1, 1'b0, 0, 0},
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'd21845, 1'b0, 0, 0},
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'd32767, 1'b0, 0, 0},
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'd32768, 1'b0, 0, 0},
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'd32769, 1'b0, 0, 0},
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'd65535, 1'b0, 0, 0},
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'd65537, 1'b0, 0, 0},
        '{ROW_CFG, REG_CTRL_POINT_1, 20'h00401, 17'd0, 1'b0, 0, 0},
        '{ROW_CFG, REG_CTRL_POINT_2, 20'h00000, 17'd0, 1'b0, 0, 0},
        '{ROW_CFG, REG_CTRL_POINT_3, 20'h00000, 17'd0, 1'b0, 0, 0},
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'd0, 1'b1, 0, 0},
        '{ROW_T, REG_CTRL_POINT_0, 20'h0, 17'd16384, 1'b0, 0, 0}
    };

    function automatic longint unsigned lerp(longint unsigned a, longint unsigned b,
                                             longint unsigned t);
        return (a * (ONE_T - t) + b * t) >> DEFAULT_T_FRAC_BITS;
    endfunction

    function automatic longint unsigned bezier_axis(longint unsigned p [4], longint unsigned t);
        longint unsigned a, b, c;
        a = lerp(p[0], p[1], t);
        b = lerp(p[1], p[2], t);
        c = lerp(p[2], p[3], t);
        return lerp(lerp(a, b, t), lerp(b, c, t), t);
    endfunction

    function automatic logic [7:0] aa_weight(longint unsigned dsq, longint unsigned d0sq);
        longint unsigned w;
        if (d0sq == 0 || dsq >= d0sq)
            return WEIGHT_FULL;
        for (w = 255; w > 0; w--)
            if (w * w * d0sq <= 65025 * dsq)
                break;
        return w[7:0];
    endfunction

    task automatic predict_writes(logic [16:0] t_raw);
        longint unsigned t, px, py, fx, fy, dx0, dy0, nx, ny, d0sq;
        longint unsigned xs [4];
        longint unsigned ys [4];
        logic signed [11:0] xi, yi, sx, sy;
        pix_write_t w;
        t = (t_raw > ONE_T) ? ONE_T : t_raw;
        for (int i = 0; i < 4; i++)
        begin
            xs[i] = longint'(ctrl_shadow[i][9:0]) << DEFAULT_T_FRAC_BITS;
            ys[i] = longint'(ctrl_shadow[i][19:10]) << DEFAULT_T_FRAC_BITS;
        end
        px = bezier_axis(xs, t);
        py = bezier_axis(ys, t);
        xi = 12'(px >> DEFAULT_T_FRAC_BITS);
        yi = 12'(py >> DEFAULT_T_FRAC_BITS);
        fx = px & (ONE_T - 1);
        fy = py & (ONE_T - 1);
        w = '{xi, yi, MODE_GREEN, WEIGHT_FULL, !aa_shadow};
        pending_writes.push_back(w);
        if (!aa_shadow)
            return;
        sx = (fx < HALF_T) ? -12'sd1 : 12'sd1;
        sy = (fy < HALF_T) ? -12'sd1 : 12'sd1;
        dx0 = (fx < HALF_T) ? HALF_T - fx : fx - HALF_T;
        dy0 = (fy < HALF_T) ? HALF_T - fy : fy - HALF_T;
        nx = ONE_T - dx0;
        ny = ONE_T - dy0;
        d0sq = dx0 * dx0 + dy0 * dy0;
        pending_writes.push_back('{xi + sx, yi, MODE_WEIGHTED,
                                   aa_weight(nx * nx + dy0 * dy0, d0sq), 1'b0});
        pending_writes.push_back('{xi, yi + sy, MODE_WEIGHTED,
                                   aa_weight(dx0 * dx0 + ny * ny, d0sq), 1'b0});
        pending_writes.push_back('{xi + sx, yi + sy, MODE_WEIGHTED,
                                   aa_weight(nx * nx + ny * ny, d0sq), 1'b1});
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [19:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_AA_ENABLE)
            aa_shadow = data[0];
        else
            ctrl_shadow[idx] = data;
    endtask

    task automatic wait_idle();
        t_if.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // one t transfer; valid stays high when the next one follows straight on
    task automatic send_t(logic [16:0] t, bit typed, int ex, int ey);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            t_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        t_if.valid <= 1'b1;
        t_if.t_value <= t;
        do
            @(posedge clk);
        while (!t_if.ready);
        if (typed)
        begin
            pending_writes.push_back('{12'(ex), 12'(ey), MODE_GREEN, WEIGHT_FULL, !aa_shadow});
            if (aa_shadow)
            begin
                // keep the typed own write, take the neighbour writes from the predictor
                predict_writes(t);
                pending_writes.delete(pending_writes.size() - 4);
            end
        end
        else
            predict_writes(t);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: random stalls per write, plus one long hold-off on request
    initial
    begin
        int wait_cycles;
        pix_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                pix_if.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            wait_cycles = rx_fast ? 0 : $urandom_range(0, 19);
            if (wait_cycles > 0)
            begin
                pix_if.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            pix_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(pix_if.valid && pix_if.ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pix_if.valid && pix_if.ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $display("%0t: write with nothing expected: x=%0d y=%0d", $realtime,
                         pix_if.pixel_x, pix_if.pixel_y);
                errors++;
            end
            else
            begin
                pix_write_t e;
                e = pending_writes.pop_front();
                if (pix_if.pixel_x !== e.x)
                begin
                    $display("%0t: pixel_x expected %0d actual %0d", $realtime, e.x, pix_if.pixel_x);
                    errors++;
                end
                if (pix_if.pixel_y !== e.y)
                begin
                    $display("%0t: pixel_y expected %0d actual %0d", $realtime, e.y, pix_if.pixel_y);
                    errors++;
                end
                if (pix_if.write_mode !== e.mode)
                begin
                    $display("%0t: write_mode expected %0d actual %0d", $realtime, e.mode,
                             pix_if.write_mode);
                    errors++;
                end
                if (pix_if.weight !== e.weight)
                begin
                    $display("%0t: weight expected %0d actual %0d", $realtime, e.weight,
                             pix_if.weight);
                    errors++;
                end
                if (pix_if.last !== e.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $realtime, e.last, pix_if.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((t_if.valid && t_if.ready) || (pix_if.valid && pix_if.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [19:0] pt;
        logic [16:0] t;
        int pick;
        errors = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        rx_fast = 1'b0;
        tx_fast = 1'b0;
        aa_shadow = 1'b0;
        for (int i = 0; i < 4; i++)
            ctrl_shadow[i] = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        t_if.valid = 1'b0;
        t_if.t_value = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(directed[i].idx, directed[i].data);
            end
            else
                send_t(directed[i].t, directed[i].typed, directed[i].ex, directed[i].ey);
        end

        for (int phase = 0; phase < 7; phase++)
        begin
            wait_idle();
            for (int i = 0; i < 4; i++)
            begin
                pick = $urandom_range(0, 5);
                pt = (pick == 0) ? 20'h00000 : (pick == 1) ? 20'hFFFFF : 20'($urandom);
                write_reg(cfg_reg_t'(i), pt);
            end
            write_reg(REG_AA_ENABLE, (phase == 2) ? 20'h1 : 20'($urandom_range(0, 1)));
            tx_fast = (phase == 2) || (phase == 5);
            rx_fast = (phase == 4);
            hold_req = (phase == 2);
            for (int n = 0; n < 35; n++)
            begin
                pick = $urandom_range(0, 9);
                t = (pick == 0) ? 17'd0 : (pick == 1) ? 17'd65536 :
                    (pick == 2) ? 17'($urandom_range(65537, 131071)) :
                    17'($urandom_range(0, 65536));
                send_t(t, 1'b0, 0, 0);
            end
        end

        t_if.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
